/* sv/qwms_pkg.sv */
// ----------------------------------------------------------------------------
// qwms_pkg
// Shared constants, operation codes, controller states and the result record
// of the sorting queue.
// ----------------------------------------------------------------------------
package qwms_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;

  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_COPY,
    ST_SETUP,
    ST_MRD,
    ST_MWR,
    ST_BACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               was_empty;
    logic               dropped;
    logic               is_empty;
    logic [6:0]         count;
  } res_t;

endpackage

/* sv/qwms_in_if.sv */
// ----------------------------------------------------------------------------
// qwms_in_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qwms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

/* sv/qwms_out_if.sv */
// ----------------------------------------------------------------------------
// qwms_out_if
// Response channel: one status record per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qwms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic               was_empty;
  logic               dropped;
  logic               is_empty;
  logic [6:0]         count;

  modport source (output valid, output out_value, output was_empty, output dropped,
                  output is_empty, output count, input ready);
  modport sink   (input valid, input out_value, input was_empty, input dropped,
                  input is_empty, input count, output ready);
endinterface

/* sv/qwms_ram.sv */
// ----------------------------------------------------------------------------
// qwms_ram
// Synchronous store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module qwms_ram #(
  parameter  int DEPTH = qwms_pkg::DEPTH_DEFAULT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic [AW-1:0]        raddr0,
  input  logic [AW-1:0]        raddr1,
  output logic signed [31:0]   rdata0,
  output logic signed [31:0]   rdata1
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* sv/qwms_ctrl.sv */
// ----------------------------------------------------------------------------
// qwms_ctrl
// Queue pointers and sequencer: enqueue, dequeue, and a bottom-up merge sort
// that ping-pongs between the entry store and the scratch store.
// ----------------------------------------------------------------------------
module qwms_ctrl #(
  parameter  int DEPTH = qwms_pkg::DEPTH_DEFAULT,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  input  logic signed [31:0]   in_value,
  output logic                 in_ready,
  input  logic                 res_take,
  output logic                 res_valid,
  output qwms_pkg::res_t       res,
  output logic                 e_we,
  output logic [AW-1:0]        e_waddr,
  output logic signed [31:0]   e_wdata,
  output logic [AW-1:0]        e_raddr0,
  output logic [AW-1:0]        e_raddr1,
  input  logic signed [31:0]   e_rdata0,
  input  logic signed [31:0]   e_rdata1,
  output logic                 s_we,
  output logic [AW-1:0]        s_waddr,
  output logic signed [31:0]   s_wdata,
  output logic [AW-1:0]        s_raddr0,
  output logic [AW-1:0]        s_raddr1,
  input  logic signed [31:0]   s_rdata0,
  input  logic signed [31:0]   s_rdata1
);

  localparam int SW = CW + 1;
  localparam int MW = CW + 2;

  qwms_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [AW-1:0]      head;
  logic signed [31:0] res_value;
  logic               res_we;
  logic               res_dr;
  logic [CW-1:0]      cc;
  logic               cp_pend;
  logic [AW-1:0]      cp_addr;
  logic [SW-1:0]      w;
  logic [CW-1:0]      lo, mid, hi, i, j, mk;
  logic               src_entry;

  logic               full;
  logic [SW-1:0]      tail_sum, copy_sum;
  logic [AW-1:0]      tail, copy_addr, head_inc;
  logic [SW-1:0]      w2;
  logic [MW-1:0]      lo_w, lo_2w;
  logic [CW-1:0]      mid_c, hi_c;
  logic signed [31:0] ma, mb, mdata;
  logic               take_i, last, run_last, pass_last;

  assign full      = count == CW'(DEPTH);
  assign tail_sum  = SW'(head) + SW'(count);
  assign tail      = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign copy_sum  = SW'(head) + SW'(cc);
  assign copy_addr = (copy_sum >= SW'(DEPTH)) ? AW'(copy_sum - SW'(DEPTH)) : AW'(copy_sum);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  assign w2        = w << 1;
  assign lo_w      = MW'(lo) + MW'(w);
  assign lo_2w     = MW'(lo) + MW'(w2);
  assign mid_c     = (lo_w >= MW'(count)) ? count : CW'(lo_w);
  assign hi_c      = (lo_2w >= MW'(count)) ? count : CW'(lo_2w);

  assign ma        = src_entry ? e_rdata0 : s_rdata0;
  assign mb        = src_entry ? e_rdata1 : s_rdata1;
  assign take_i    = (i < mid) && ((j >= hi) || (ma <= mb));
  assign mdata     = take_i ? ma : mb;
  assign last      = CW'(mk + 1'b1) == hi;
  assign run_last  = hi == count;
  assign pass_last = w2 >= SW'(count);

  assign in_ready  = state == qwms_pkg::ST_IDLE;
  assign res_valid = state == qwms_pkg::ST_DONE;

  assign res.out_value = res_value;
  assign res.was_empty = res_we;
  assign res.dropped   = res_dr;
  assign res.is_empty  = count == '0;
  assign res.count     = 7'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qwms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    e_we     = 1'b0;
    e_waddr  = tail;
    e_wdata  = in_value;
    e_raddr0 = head;
    e_raddr1 = AW'(j);
    s_we     = 1'b0;
    s_waddr  = cp_addr;
    s_wdata  = e_rdata0;
    s_raddr0 = AW'(i);
    s_raddr1 = AW'(j);
    unique case (state)
      qwms_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority case (in_op)
            qwms_pkg::OP_ENQ: begin
              e_we       = !full;
              state_next = qwms_pkg::ST_DONE;
            end
            qwms_pkg::OP_DEQ: begin
              state_next = (count == '0) ? qwms_pkg::ST_DONE : qwms_pkg::ST_DEQ;
            end
            qwms_pkg::OP_SORT: begin
              state_next = (count >= CW'(2)) ? qwms_pkg::ST_COPY : qwms_pkg::ST_DONE;
            end
            default: state_next = qwms_pkg::ST_DONE;
          endcase
        end
      end
      qwms_pkg::ST_DEQ: state_next = qwms_pkg::ST_DONE;
      qwms_pkg::ST_COPY: begin
        e_raddr0 = copy_addr;
        s_we     = cp_pend;
        s_waddr  = cp_addr;
        s_wdata  = e_rdata0;
        if (cc == count) begin
          state_next = qwms_pkg::ST_SETUP;
        end
      end
      qwms_pkg::ST_SETUP: state_next = qwms_pkg::ST_MRD;
      qwms_pkg::ST_MRD: begin
        e_raddr0   = AW'(i);
        e_raddr1   = AW'(j);
        state_next = qwms_pkg::ST_MWR;
      end
      qwms_pkg::ST_MWR: begin
        if (src_entry) begin
          s_we    = 1'b1;
          s_waddr = AW'(mk);
          s_wdata = mdata;
        end else begin
          e_we    = 1'b1;
          e_waddr = AW'(mk);
          e_wdata = mdata;
        end
        if (last) begin
          if (run_last && pass_last) begin
            state_next = src_entry ? qwms_pkg::ST_BACK : qwms_pkg::ST_DONE;
          end else begin
            state_next = qwms_pkg::ST_SETUP;
          end
        end else begin
          state_next = qwms_pkg::ST_MRD;
        end
      end
      qwms_pkg::ST_BACK: begin
        s_raddr0 = AW'(cc);
        e_we     = cp_pend;
        e_waddr  = cp_addr;
        e_wdata  = s_rdata0;
        if (cc == count) begin
          state_next = qwms_pkg::ST_DONE;
        end
      end
      qwms_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = qwms_pkg::ST_IDLE;
        end
      end
      default: state_next = qwms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      head    <= '0;
      cp_pend <= 1'b0;
    end else begin
      unique case (state)
        qwms_pkg::ST_IDLE: begin
          if (in_valid) begin
            res_value <= '0;
            res_we    <= 1'b0;
            res_dr    <= 1'b0;
            cc        <= '0;
            cp_pend   <= 1'b0;
            w         <= SW'(1);
            lo        <= '0;
            src_entry <= 1'b0;
            priority case (in_op)
              qwms_pkg::OP_ENQ: begin
                if (full) begin
                  res_dr <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              qwms_pkg::OP_DEQ: begin
                if (count == '0) begin
                  res_value <= qwms_pkg::EMPTY_VALUE;
                  res_we    <= 1'b1;
                end else begin
                  head  <= head_inc;
                  count <= count - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        qwms_pkg::ST_DEQ: res_value <= e_rdata0;
        qwms_pkg::ST_COPY, qwms_pkg::ST_BACK: begin
          if (cc != count) begin
            cc      <= cc + 1'b1;
            cp_pend <= 1'b1;
            cp_addr <= AW'(cc);
          end else begin
            cp_pend <= 1'b0;
            if (state == qwms_pkg::ST_BACK) begin
              head <= '0;
            end
          end
        end
        qwms_pkg::ST_SETUP: begin
          mid <= mid_c;
          hi  <= hi_c;
          i   <= lo;
          j   <= mid_c;
          mk  <= lo;
        end
        qwms_pkg::ST_MWR: begin
          if (take_i) begin
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
          mk <= mk + 1'b1;
          if (last) begin
            if (run_last) begin
              w         <= w2;
              src_entry <= !src_entry;
              lo        <= '0;
              if (pass_last) begin
                cc      <= '0;
                cp_pend <= 1'b0;
                if (!src_entry) begin
                  head <= '0;
                end
              end
            end else begin
              lo <= hi;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/queue_with_merge_sort_top.sv */
// ----------------------------------------------------------------------------
// queue_with_merge_sort_top
// Bounded FIFO of signed 32-bit values that can sort its contents in place.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction: enqueue a value, dequeue the
//   oldest value, or sort the held values into ascending order. rsp returns
//   exactly one status record per request, in request order.
//   Enqueue, no-op, empty dequeue and a sort of fewer than two entries go
//   straight to the response; a dequeue first reads the entry store. A sort
//   of n >= 2 entries copies them into the scratch store, then runs
//   ceil(log2 n) merge passes, each a read-compare-write step per element
//   on the store ports, copies back when the last pass ends in the scratch
//   store, and then presents its result to rsp.
//   One request is in progress at a time; req.ready is high while idle,
//   also while a finished response still waits in the rsp register. A new
//   request is accepted only once the previous result has been handed
//   over. If rsp is stalled, the next result waits in the controller and
//   req stays not ready until it is handed over.
//   Reset empties the queue; store contents are not cleared.
// ----------------------------------------------------------------------------
module queue_with_merge_sort_top #(
  parameter  int DEPTH = qwms_pkg::DEPTH_DEFAULT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  qwms_in_if.sink     req,
  qwms_out_if.source  rsp
);

  logic               e_we, s_we;
  logic [AW-1:0]      e_waddr, e_raddr0, e_raddr1, s_waddr, s_raddr0, s_raddr1;
  logic signed [31:0] e_wdata, e_rdata0, e_rdata1, s_wdata, s_rdata0, s_rdata1;
  logic               res_valid, res_take;
  qwms_pkg::res_t     res;

  qwms_ram #(.DEPTH(DEPTH)) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr0(e_raddr0), .raddr1(e_raddr1), .rdata0(e_rdata0), .rdata1(e_rdata1)
  );

  qwms_ram #(.DEPTH(DEPTH)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr0(s_raddr0), .raddr1(s_raddr1), .rdata0(s_rdata0), .rdata1(s_rdata1)
  );

  qwms_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_op(req.op), .in_value(req.value), .in_ready(req.ready),
    .res_take(res_take), .res_valid(res_valid), .res(res),
    .e_we(e_we), .e_waddr(e_waddr), .e_wdata(e_wdata),
    .e_raddr0(e_raddr0), .e_raddr1(e_raddr1), .e_rdata0(e_rdata0), .e_rdata1(e_rdata1),
    .s_we(s_we), .s_waddr(s_waddr), .s_wdata(s_wdata),
    .s_raddr0(s_raddr0), .s_raddr1(s_raddr1), .s_rdata0(s_rdata0), .s_rdata1(s_rdata1)
  );

  assign res_take = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp.out_value <= res.out_value;
      rsp.was_empty <= res.was_empty;
      rsp.dropped   <= res.dropped;
      rsp.is_empty  <= res.is_empty;
      rsp.count     <= res.count;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_take |=> rsp.valid)
    else $error("pending result not loaded into response register");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && res_valid))
    else $error("request accepted while a result is pending");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.was_empty |-> rsp.out_value == qwms_pkg::EMPTY_VALUE && rsp.is_empty)
    else $error("empty dequeue reported inconsistently");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.was_empty && rsp.dropped))
    else $error("empty and dropped flags both set");

endmodule
